>>> hw/rtl/iracfpe_pkg.sv
package iracfpe_pkg;

    localparam int FRAME_BYTES   = 18;
    localparam int TEMP_BYTE_POS = 7;
    localparam int CSUM_BYTE_POS = 17;
    localparam int DUR_W         = 15;
    localparam int CFG_IDX_W     = 3;
    localparam int POS_W         = 8;

    localparam logic [POS_W-1:0] LAST_WORD_POS = POS_W'(145);
    localparam logic [7:0]       TEMP_OFFSET   = 8'd16;

    localparam logic [7:0] FRAME_TEMPLATE [FRAME_BYTES] = '{
        8'h23, 8'hCB, 8'h26, 8'h01, 8'h00, 8'h20, 8'h18, 8'h00, 8'h30,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Sum of the fixed bytes that feed the checksum (the temperature slot is zero).
    function automatic logic [7:0] template_sum();
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < CSUM_BYTE_POS; k++) begin
            acc = acc + FRAME_TEMPLATE[k];
        end
        return acc;
    endfunction

    localparam logic [7:0] TEMPLATE_SUM = template_sum();

    localparam logic [15:0] RST_HEADER_MARK  = 16'd3400;
    localparam logic [15:0] RST_HEADER_SPACE = 16'd1750;
    localparam logic [15:0] RST_BIT_MARK     = 16'd450;
    localparam logic [15:0] RST_ONE_SPACE    = 16'd1300;
    localparam logic [15:0] RST_ZERO_SPACE   = 16'd420;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_MARK  = 3'd0,
        CFG_HEADER_SPACE = 3'd1,
        CFG_BIT_MARK     = 3'd2,
        CFG_ONE_SPACE    = 3'd3,
        CFG_ZERO_SPACE   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic       start_frame;
        logic [7:0] temperature;
        logic       power_on;
    } t_in_req;

    typedef struct packed {
        logic [DUR_W-1:0] first_duration;
        logic             first_level;
        logic [DUR_W-1:0] second_duration;
        logic             second_level;
        logic             word_valid;
        logic             last_word;
    } t_out_req;

    typedef struct packed {
        logic load;
        logic shift;
    } t_chain_ctl;

endpackage

>>> hw/rtl/iracfpe_cell.sv
module iracfpe_cell (
    input  logic                    i_clk,
    input  iracfpe_pkg::t_chain_ctl i_ctl,
    input  logic [7:0]              i_load_byte,
    input  logic                    i_shift_in,
    output logic                    o_shift_out
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.load) begin
            n_byte = i_load_byte;
        end else if (i_ctl.shift) begin
            n_byte = {i_shift_in, r_byte[7:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_shift_out = r_byte[0];

endmodule

>>> hw/rtl/iracfpe_chain.sv
module iracfpe_chain (
    input  logic                    i_clk,
    input  iracfpe_pkg::t_chain_ctl i_ctl,
    input  logic [7:0]              i_temp_byte,
    input  logic [7:0]              i_csum_byte,
    output logic                    o_head_bit
);

    logic [iracfpe_pkg::FRAME_BYTES:0] w_link;

    assign w_link[iracfpe_pkg::FRAME_BYTES] = 1'b0;

    for (genvar g = 0; g < iracfpe_pkg::FRAME_BYTES; g++) begin : g_cell
        logic [7:0] w_load;

        if (g == iracfpe_pkg::TEMP_BYTE_POS) begin : g_temp
            assign w_load = i_temp_byte;
        end else if (g == iracfpe_pkg::CSUM_BYTE_POS) begin : g_csum
            assign w_load = i_csum_byte;
        end else begin : g_fixed
            assign w_load = iracfpe_pkg::FRAME_TEMPLATE[g];
        end

        iracfpe_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_load_byte (w_load),
            .i_shift_in  (w_link[g+1]),
            .o_shift_out (w_link[g])
        );
    end

    assign o_head_bit = w_link[0];

endmodule

>>> hw/rtl/ir_ac_frame_pulse_encoder.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_req  (start, temperature, power)
// out       output     o_out_valid / i_out_stall o_out_req (one pulse word)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each request yields one pulse word in the output register on the next cycle, and a new request is taken
// every cycle while the output register is empty or being drained.
// The frame sits in a chain of byte cells loaded on start and shifted one bit per data word.
// Reset restores the default timings and leaves the encoder idle.
// A stalled output holds the word and stalls the input; configuration is always ready.
module ir_ac_frame_pulse_encoder (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  iracfpe_pkg::t_in_req                  i_in_req,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output iracfpe_pkg::t_out_req                 o_out_req,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [iracfpe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [iracfpe_pkg::DUR_W-1:0]         i_cfg_data
);

    localparam int DW = iracfpe_pkg::DUR_W;
    localparam int PW = iracfpe_pkg::POS_W;

    logic [DW-1:0] r_header_mark, r_header_space, r_bit_mark, r_one_space, r_zero_space;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_busy, n_busy;
    logic          r_out_valid;
    iracfpe_pkg::t_out_req   r_out, n_out;
    iracfpe_pkg::t_chain_ctl w_ctl;
    logic          w_accept;
    logic          w_head_bit;
    logic [7:0]    w_temp_byte, w_csum_byte;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_mark  <= DW'(iracfpe_pkg::RST_HEADER_MARK);
            r_header_space <= DW'(iracfpe_pkg::RST_HEADER_SPACE);
            r_bit_mark     <= DW'(iracfpe_pkg::RST_BIT_MARK);
            r_one_space    <= DW'(iracfpe_pkg::RST_ONE_SPACE);
            r_zero_space   <= DW'(iracfpe_pkg::RST_ZERO_SPACE);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                iracfpe_pkg::CFG_HEADER_MARK:  r_header_mark  <= i_cfg_data;
                iracfpe_pkg::CFG_HEADER_SPACE: r_header_space <= i_cfg_data;
                iracfpe_pkg::CFG_BIT_MARK:     r_bit_mark     <= i_cfg_data;
                iracfpe_pkg::CFG_ONE_SPACE:    r_one_space    <= i_cfg_data;
                iracfpe_pkg::CFG_ZERO_SPACE:   r_zero_space   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_temp_byte = i_in_req.temperature - iracfpe_pkg::TEMP_OFFSET;
    assign w_csum_byte = w_temp_byte + iracfpe_pkg::TEMPLATE_SUM;

    always_comb begin
        n_pos     = r_pos;
        n_busy    = r_busy;
        n_out     = '0;
        w_ctl     = '0;
        if (w_accept) begin
            if (i_in_req.start_frame) begin
                w_ctl.load            = 1'b1;
                n_out.first_duration  = r_header_mark;
                n_out.first_level     = 1'b1;
                n_out.second_duration = r_header_space;
                n_out.word_valid      = 1'b1;
                n_pos                 = PW'(1);
                n_busy                = 1'b1;
            end else if (r_busy) begin
                n_out.first_duration = r_bit_mark;
                n_out.first_level    = 1'b1;
                n_out.word_valid     = 1'b1;
                if (r_pos >= iracfpe_pkg::LAST_WORD_POS) begin
                    n_out.last_word = 1'b1;
                    n_pos           = '0;
                    n_busy          = 1'b0;
                end else begin
                    w_ctl.shift           = 1'b1;
                    n_out.second_duration = w_head_bit ? r_one_space : r_zero_space;
                    n_pos                 = r_pos + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_busy <= n_busy;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    iracfpe_chain u_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_temp_byte (w_temp_byte),
        .i_csum_byte (w_csum_byte),
        .o_head_bit  (w_head_bit)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule
